>>> rtl/core/usm_pkg.sv
// ----------------------------------------------------------------------------
// usm_pkg
// Shared types, constants and the Gaussian tap ROM for the unsharp mask block.
// ----------------------------------------------------------------------------
package usm_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_HEIGHT   = 4096;
  localparam int MAX_RADIUS   = 3;
  localparam int MAX_CHANNELS = 4;
  localparam int STORE_LINES  = 2 * MAX_RADIUS + 1;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int SLOT_W       = $clog2(STORE_LINES);
  localparam int ADDR_W       = SLOT_W + COL_W;
  localparam int MEM_DEPTH    = STORE_LINES * MAX_WIDTH;
  localparam int PIX_W        = 8 * MAX_CHANNELS;

  localparam logic [11:0] RST_WIDTH   = 12'd640;
  localparam logic [12:0] RST_HEIGHT  = 13'd480;
  localparam logic [1:0]  RST_RADIUS  = 2'd1;
  localparam logic [11:0] RST_AMOUNT  = 12'd256;
  localparam logic [7:0]  RST_THRESH  = 8'd0;
  localparam logic [2:0]  RST_CHANS   = 3'd1;

  // floor(v/7) == (v*MOD7_RECIP) >> MOD7_SHIFT for v < 4096
  localparam logic [11:0] MOD7_RECIP  = 12'd2341;
  localparam int          MOD7_SHIFT  = 14;

  typedef enum logic [2:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_RADIUS = 3'd2,
    CFG_AMOUNT = 3'd3,
    CFG_THRESH = 3'd4,
    CFG_CHANS  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [11:0] w;
    logic [12:0] h;
    logic [1:0]  r;
    logic [11:0] amount;
    logic [7:0]  thresh;
    logic [2:0]  nc;
  } cfg_t;

  typedef struct packed {
    logic              wr;
    logic [SLOT_W-1:0] wr_slot;
    logic [COL_W-1:0]  wr_col;
    logic              addr;
    logic              rd;
    logic              lat_src;
    logic              clr;
    logic              acc_v;
    logic              acc_h;
    logic              blur;
    logic              sharp;
    logic              load;
    logic              last;
    logic [ROW_W-1:0]  y;
    logic [COL_W-1:0]  x;
    logic [2:0]        i;
    logic [2:0]        j;
  } cmd_t;

  // Q0.16 Gaussian taps, centre first
  function automatic logic [15:0] tap(input logic [1:0] r, input logic [1:0] k);
    logic [15:0] t;
    case ({r, k})
      4'b01_00: t = 16'd34210;
      4'b01_01: t = 16'd15663;
      4'b10_00: t = 16'd24218;
      4'b10_01: t = 16'd16021;
      4'b10_10: t = 16'd4638;
      4'b11_00: t = 16'd18876;
      4'b11_01: t = 16'd14626;
      4'b11_10: t = 16'd6804;
      4'b11_11: t = 16'd1900;
      default:  t = 16'd0;
    endcase
    return t;
  endfunction

endpackage

>>> rtl/core/usm_pix_if.sv
// ----------------------------------------------------------------------------
// usm_pix_if
// Input pixel channel: valid/ready with four 8-bit channel samples.
// ----------------------------------------------------------------------------
interface usm_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan0_in;
  logic [7:0] chan1_in;
  logic [7:0] chan2_in;
  logic [7:0] chan3_in;

  modport source (output valid, chan0_in, chan1_in, chan2_in, chan3_in, input ready);
  modport sink   (input valid, chan0_in, chan1_in, chan2_in, chan3_in, output ready);
endinterface

>>> rtl/core/usm_res_if.sv
// ----------------------------------------------------------------------------
// usm_res_if
// Result channel: valid/ready with sharpened pixel, position and run marker.
// ----------------------------------------------------------------------------
interface usm_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  chan0_out;
  logic [7:0]  chan1_out;
  logic [7:0]  chan2_out;
  logic [7:0]  chan3_out;
  logic [11:0] out_row;
  logic [10:0] out_col;
  logic        last_of_run;

  modport source (output valid, chan0_out, chan1_out, chan2_out, chan3_out, out_row, out_col,
                  last_of_run, input ready);
  modport sink   (input valid, chan0_out, chan1_out, chan2_out, chan3_out, out_row, out_col,
                  last_of_run, output ready);
endinterface

>>> rtl/core/usm_cfg_if.sv
// ----------------------------------------------------------------------------
// usm_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface usm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [12:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/usm_cfg_regs.sv
// ----------------------------------------------------------------------------
// usm_cfg_regs
// Configuration registers with range clamping and frame restart strobe.
// ----------------------------------------------------------------------------
module usm_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  usm_cfg_if.sink        cfg_wr,
  output usm_pkg::cfg_t  cfg,
  output logic           restart
);

  logic [11:0] width_r;
  logic [12:0] height_r;
  logic [1:0]  radius_r;
  logic [11:0] amount_r;
  logic [7:0]  thresh_r;
  logic [2:0]  chans_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= usm_pkg::RST_WIDTH;
      height_r <= usm_pkg::RST_HEIGHT;
      radius_r <= usm_pkg::RST_RADIUS;
      amount_r <= usm_pkg::RST_AMOUNT;
      thresh_r <= usm_pkg::RST_THRESH;
      chans_r  <= usm_pkg::RST_CHANS;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        usm_pkg::CFG_WIDTH:  width_r  <= cfg_wr.data[11:0];
        usm_pkg::CFG_HEIGHT: height_r <= cfg_wr.data[12:0];
        usm_pkg::CFG_RADIUS: radius_r <= cfg_wr.data[1:0];
        usm_pkg::CFG_AMOUNT: amount_r <= cfg_wr.data[11:0];
        usm_pkg::CFG_THRESH: thresh_r <= cfg_wr.data[7:0];
        usm_pkg::CFG_CHANS:  chans_r  <= cfg_wr.data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_wr.index)
      usm_pkg::CFG_WIDTH, usm_pkg::CFG_HEIGHT, usm_pkg::CFG_RADIUS,
      usm_pkg::CFG_AMOUNT, usm_pkg::CFG_THRESH, usm_pkg::CFG_CHANS: restart = cfg_wr.valid;
      default: restart = 1'b0;
    endcase
  end

  always_comb begin
    cfg.w = (width_r < 12'd8) ? 12'd8 :
            (width_r > 12'(usm_pkg::MAX_WIDTH)) ? 12'(usm_pkg::MAX_WIDTH) : width_r;
    cfg.h = (height_r < 13'd8) ? 13'd8 :
            (height_r > 13'(usm_pkg::MAX_HEIGHT)) ? 13'(usm_pkg::MAX_HEIGHT) : height_r;
    cfg.r = (radius_r == 2'd0) ? 2'd1 : radius_r;
    cfg.amount = amount_r;
    cfg.thresh = thresh_r;
    cfg.nc = (chans_r == 3'd0) ? 3'd1 :
             (chans_r > 3'(usm_pkg::MAX_CHANNELS)) ? 3'(usm_pkg::MAX_CHANNELS) : chans_r;
  end

endmodule

>>> rtl/core/usm_ctrl.sv
// ----------------------------------------------------------------------------
// usm_ctrl
// Sequencer: raster counters, output enumeration and the per-tap walk.
// ----------------------------------------------------------------------------
module usm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  usm_pkg::cfg_t cfg,
  input  logic          restart,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output usm_pkg::cmd_t cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_SRC_A = 12'b0000_0000_0010,
    S_SRC_R = 12'b0000_0000_0100,
    S_SRC_L = 12'b0000_0000_1000,
    S_TAP_A = 12'b0000_0001_0000,
    S_TAP_R = 12'b0000_0010_0000,
    S_TAP_V = 12'b0000_0100_0000,
    S_TAP_H = 12'b0000_1000_0000,
    S_BLUR  = 12'b0001_0000_0000,
    S_SHARP = 12'b0010_0000_0000,
    S_LOAD  = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [usm_pkg::ROW_W-1:0]  row_r, y_r, yend_r;
  logic [usm_pkg::COL_W-1:0]  col_r, x_r, x0_r, xend_r;
  logic [usm_pkg::SLOT_W-1:0] slot_r;
  logic [2:0]                 i_r, j_r;

  logic       accept, has_out, last_col, last_row, last, i_end, j_end;
  logic [2:0] pos_r, neg_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign accept    = in_valid && in_ready;
  assign pos_r     = {1'b0, cfg.r};
  assign neg_r     = 3'd0 - pos_r;
  assign has_out   = (row_r >= 12'(cfg.r)) && (col_r >= 11'(cfg.r));
  assign last_col  = ({1'b0, col_r} == (cfg.w - 12'd1));
  assign last_row  = ({1'b0, row_r} == (cfg.h - 13'd1));
  assign last      = (y_r == yend_r) && (x_r == xend_r);
  assign i_end     = (i_r == pos_r);
  assign j_end     = (j_r == pos_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept && has_out) state_nxt = S_SRC_A;
      S_SRC_A: state_nxt = S_SRC_R;
      S_SRC_R: state_nxt = S_SRC_L;
      S_SRC_L: state_nxt = S_TAP_A;
      S_TAP_A: state_nxt = S_TAP_R;
      S_TAP_R: state_nxt = S_TAP_V;
      S_TAP_V: state_nxt = i_end ? S_TAP_H : S_TAP_A;
      S_TAP_H: state_nxt = j_end ? S_BLUR : S_TAP_A;
      S_BLUR:  state_nxt = S_SHARP;
      S_SHARP: state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_OUT;
      S_OUT:   if (out_ready) state_nxt = last ? S_IDLE : S_SRC_A;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (restart) begin
        row_r  <= '0;
        col_r  <= '0;
        slot_r <= '0;
      end else if (accept) begin
        if (last_col) begin
          col_r <= '0;
          if (last_row) begin
            row_r  <= '0;
            slot_r <= '0;
          end else begin
            row_r  <= row_r + 12'd1;
            slot_r <= (slot_r == 3'(usm_pkg::STORE_LINES - 1)) ? 3'd0 : slot_r + 3'd1;
          end
        end else begin
          col_r <= col_r + 11'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      y_r    <= row_r - 12'(cfg.r);
      x_r    <= col_r - 11'(cfg.r);
      x0_r   <= col_r - 11'(cfg.r);
      yend_r <= last_row ? row_r : row_r - 12'(cfg.r);
      xend_r <= last_col ? col_r : col_r - 11'(cfg.r);
      i_r    <= 3'd0;
      j_r    <= 3'd0;
    end
    case (state_r)
      S_SRC_R: begin
        i_r <= neg_r;
        j_r <= neg_r;
      end
      S_TAP_V: if (!i_end) i_r <= i_r + 3'd1;
      S_TAP_H: if (!j_end) begin
        j_r <= j_r + 3'd1;
        i_r <= neg_r;
      end
      S_OUT: if (out_ready && !last) begin
        i_r <= 3'd0;
        j_r <= 3'd0;
        if (x_r == xend_r) begin
          x_r <= x0_r;
          y_r <= y_r + 12'd1;
        end else begin
          x_r <= x_r + 11'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd.wr      = accept;
    cmd.wr_slot = slot_r;
    cmd.wr_col  = col_r;
    cmd.addr    = (state_r == S_SRC_A) || (state_r == S_TAP_A);
    cmd.rd      = (state_r == S_SRC_R) || (state_r == S_TAP_R);
    cmd.lat_src = (state_r == S_SRC_L);
    cmd.clr     = (state_r == S_SRC_R);
    cmd.acc_v   = (state_r == S_TAP_V);
    cmd.acc_h   = (state_r == S_TAP_H);
    cmd.blur    = (state_r == S_BLUR);
    cmd.sharp   = (state_r == S_SHARP);
    cmd.load    = (state_r == S_LOAD);
    cmd.last    = last;
    cmd.y       = y_r;
    cmd.x       = x_r;
    cmd.i       = i_r;
    cmd.j       = j_r;
  end

endmodule

>>> rtl/core/usm_dp.sv
// ----------------------------------------------------------------------------
// usm_dp
// Datapath: line store, reflected addressing, separable blur MACs, sharpen.
// ----------------------------------------------------------------------------
module usm_dp (
  input  logic          clk,
  input  usm_pkg::cfg_t cfg,
  input  usm_pkg::cmd_t cmd,
  input  logic [7:0]    chan0_in,
  input  logic [7:0]    chan1_in,
  input  logic [7:0]    chan2_in,
  input  logic [7:0]    chan3_in,
  output logic [7:0]    chan0_out,
  output logic [7:0]    chan1_out,
  output logic [7:0]    chan2_out,
  output logic [7:0]    chan3_out,
  output logic [11:0]   out_row,
  output logic [10:0]   out_col,
  output logic          last_of_run
);

  localparam int NC = usm_pkg::MAX_CHANNELS;

  logic [usm_pkg::PIX_W-1:0] mem [0:usm_pkg::MEM_DEPTH-1];

  logic [usm_pkg::PIX_W-1:0]  pix, rdata_r, src_r;
  logic [usm_pkg::ROW_W-1:0]  yy_r;
  logic [usm_pkg::COL_W-1:0]  xx_r;
  logic [14:0]                ty, tx, hm1, wm1, ry, rx;
  logic [23:0]                qprod;
  logic [11:0]                q7;
  logic [usm_pkg::SLOT_W-1:0] rslot;
  logic [1:0]                 ki, kj;
  logic [15:0]                ti, tj;

  logic [23:0]        vs_r  [NC];
  logic [32:0]        hs_r  [NC];
  logic [7:0]         blur_r[NC];
  logic signed [23:0] n_r   [NC];
  logic               sharp_r;

  logic [7:0]  cin [NC];
  logic [7:0]  s   [NC];
  logic [7:0]  res [NC];
  logic [23:0] vrnd[NC];
  logic [32:0] hrnd[NC];
  logic signed [8:0]  d  [NC];
  logic [7:0]         mag[NC];
  logic signed [23:0] nn [NC];
  logic [7:0]  detail;
  logic [24:0] nr  [NC];

  assign cin[0] = chan0_in;
  assign cin[1] = chan1_in;
  assign cin[2] = chan2_in;
  assign cin[3] = chan3_in;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      pix[8*c +: 8] = (3'(c) < cfg.nc) ? cin[c] : 8'd0;
    end
  end

  // reflect-101 on both axes
  always_comb begin
    ty  = {3'b0, cmd.y} + {{12{cmd.i[2]}}, cmd.i};
    tx  = {4'b0, cmd.x} + {{12{cmd.j[2]}}, cmd.j};
    hm1 = {2'b0, cfg.h} - 15'd1;
    wm1 = {3'b0, cfg.w} - 15'd1;
    ry  = ty[14] ? 15'd0 - ty : ty;
    rx  = tx[14] ? 15'd0 - tx : tx;
    if (ry > hm1) ry = {hm1[13:0], 1'b0} - ry;
    if (rx > wm1) rx = {wm1[13:0], 1'b0} - rx;
  end

  always_comb begin
    qprod = 24'(yy_r) * 24'(usm_pkg::MOD7_RECIP);
    q7    = 12'(qprod[23:usm_pkg::MOD7_SHIFT]) * 12'd7;
    rslot = 3'(yy_r - q7);
    ki    = cmd.i[2] ? 2'(3'd0 - cmd.i) : cmd.i[1:0];
    kj    = cmd.j[2] ? 2'(3'd0 - cmd.j) : cmd.j[1:0];
    ti    = usm_pkg::tap(cfg.r, ki);
    tj    = usm_pkg::tap(cfg.r, kj);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) mem[{cmd.wr_slot, cmd.wr_col}] <= pix;
    if (cmd.rd) rdata_r <= mem[{rslot, xx_r}];
  end

  always_ff @(posedge clk) begin
    if (cmd.addr) begin
      yy_r <= ry[usm_pkg::ROW_W-1:0];
      xx_r <= rx[usm_pkg::COL_W-1:0];
    end
    if (cmd.lat_src) src_r <= rdata_r;
  end

  always_comb begin
    detail = 8'd0;
    for (int c = 0; c < NC; c++) begin
      s[c]    = src_r[8*c +: 8];
      vrnd[c] = vs_r[c] + 24'd128;
      hrnd[c] = hs_r[c] + 33'h0_0080_0000;
      d[c]    = $signed({1'b0, s[c]}) - $signed({1'b0, blur_r[c]});
      mag[c]  = d[c][8] ? 8'(9'd0 - d[c]) : d[c][7:0];
      nn[c]   = $signed({8'd0, s[c], 8'd0}) +
                24'($signed({1'b0, cfg.amount}) * d[c]);
      if ((3'(c) < cfg.nc) && (mag[c] > detail)) detail = mag[c];
      nr[c]   = 25'($signed(n_r[c])) + 25'sd128;
      if (3'(c) >= cfg.nc) res[c] = 8'd0;
      else if (!sharp_r) res[c] = s[c];
      else if (n_r[c][23]) res[c] = 8'd0;
      else if (nr[c][23:16] != 8'd0) res[c] = 8'd255;
      else res[c] = nr[c][15:8];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NC; c++) begin
      if (cmd.clr) begin
        vs_r[c] <= '0;
        hs_r[c] <= '0;
      end else if (cmd.acc_v) begin
        vs_r[c] <= vs_r[c] + 24'(ti * rdata_r[8*c +: 8]);
      end else if (cmd.acc_h) begin
        hs_r[c] <= hs_r[c] + 33'(tj * vrnd[c][23:8]);
        vs_r[c] <= '0;
      end
      if (cmd.blur)  blur_r[c] <= hrnd[c][31:24];
      if (cmd.sharp) n_r[c] <= nn[c];
    end
    if (cmd.sharp) sharp_r <= (detail > cfg.thresh);
    if (cmd.load) begin
      chan0_out   <= res[0];
      chan1_out   <= res[1];
      chan2_out   <= res[2];
      chan3_out   <= res[3];
      out_row     <= cmd.y;
      out_col     <= cmd.x;
      last_of_run <= cmd.last;
    end
  end

endmodule

>>> rtl/core/unsharp_mask_sharpen.sv
// ----------------------------------------------------------------------------
// unsharp_mask_sharpen
// Streaming unsharp mask with detail threshold over 1 to 4 channel pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in_pix  : raster-order pixels, one beat per pixel.
//   out_res : sharpened pixels with row/col; last_of_run marks the final
//             result beat caused by one input beat.
//   cfg_wr  : register writes (index 0..5), always ready; any write to a
//             listed register restarts the frame at row 0, column 0.
// An input beat that completes no output window leaves in_ready high. Each
// result then takes one line-store read per kernel tap, K*K taps with
// K = 2*radius+1, on the single memory port; in_ready returns the cycle
// after the last beat of a run. After an accepting edge that completes an
// output window, in_ready is low until the run is delivered.
// A result stays on out_res with valid high until taken; the receiver may
// stall as long as it likes. Reset restores register defaults and row and
// column zero; line-store contents are left as they are.
// ----------------------------------------------------------------------------
module unsharp_mask_sharpen (
  input  logic      clk,
  input  logic      rst_n,
  usm_pix_if.sink   in_pix,
  usm_res_if.source out_res,
  usm_cfg_if.sink   cfg_wr
);

  usm_pkg::cfg_t cfg;
  usm_pkg::cmd_t cmd;
  logic          restart;

  usm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (cfg_wr),
    .cfg     (cfg),
    .restart (restart)
  );

  usm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .restart   (restart),
    .in_valid  (in_pix.valid),
    .in_ready  (in_pix.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .cmd       (cmd)
  );

  usm_dp u_dp (
    .clk         (clk),
    .cfg         (cfg),
    .cmd         (cmd),
    .chan0_in    (in_pix.chan0_in),
    .chan1_in    (in_pix.chan1_in),
    .chan2_in    (in_pix.chan2_in),
    .chan3_in    (in_pix.chan3_in),
    .chan0_out   (out_res.chan0_out),
    .chan1_out   (out_res.chan1_out),
    .chan2_out   (out_res.chan2_out),
    .chan3_out   (out_res.chan3_out),
    .out_row     (out_res.out_row),
    .out_col     (out_res.out_col),
    .last_of_run (out_res.last_of_run)
  );

endmodule

>>> rtl/core/usm_checker.sv
// ----------------------------------------------------------------------------
// usm_checker
// Port-level checks for unsharp_mask_sharpen, bound to the top level.
// ----------------------------------------------------------------------------
module usm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_last,
  input logic [11:0] out_row,
  input logic [10:0] out_col
);

  // no result while still reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // one item at a time: never taking input while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("input ready while result pending");

  // end of run hands control back to the input side
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_ready && out_last |=> in_ready && !out_valid)
    else $error("input not ready after end of run");

  // stalled beat holds position
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col))
    else $error("stalled result beat changed");

  // accepted input is not followed at once by a valid result
  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
      in_valid && in_ready && !out_valid |=> out_valid == 1'b0)
    else $error("result appeared the cycle after input");

endmodule

bind unsharp_mask_sharpen usm_checker u_usm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pix.valid),
  .in_ready  (in_pix.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_last  (out_res.last_of_run),
  .out_row   (out_res.out_row),
  .out_col   (out_res.out_col)
);
